@@ sv/rip_pkg.sv @@
`default_nettype none
package rip_pkg;

   // operation codes of a request word
   localparam logic [1:0] OP_TICK   = 2'd0;
   localparam logic [1:0] OP_INTENT = 2'd1;
   localparam logic [1:0] OP_WAKE   = 2'd2;

   // reported policy states
   localparam logic [2:0] ST_OFF       = 3'd0;
   localparam logic [2:0] ST_WAKING    = 3'd1;
   localparam logic [2:0] ST_PARKED    = 3'd2;
   localparam logic [2:0] ST_LINK_IDLE = 3'd3;
   localparam logic [2:0] ST_BUSY      = 3'd4;
   localparam logic [2:0] ST_SEARCH    = 3'd5;

   // applied modem sleep modes
   localparam logic [1:0] SAVE_NONE = 2'd0;
   localparam logic [1:0] SAVE_MIN  = 2'd1;
   localparam logic [1:0] SAVE_MAX  = 2'd2;

   // configuration register indexes
   localparam logic [1:0] REG_AUTO_PARK  = 2'd0;
   localparam logic [1:0] REG_POWER_SAVE = 2'd1;
   localparam logic [1:0] REG_IDLE_MIN   = 2'd2;
   localparam logic [1:0] REG_RETRY_MIN  = 2'd3;

   localparam logic [15:0] LOOK_SECONDS  = 16'd45;
   localparam logic [15:0] AWAY_SECONDS  = 16'd60;
   localparam logic [15:0] SECS_PER_MIN  = 16'd60;
   localparam logic [15:0] COUNT_MAX     = 16'hFFFF;

   typedef struct packed {
      logic       auto_park_enable;
      logic       power_save_enable;
      logic [9:0] idle_minutes;
      logic [9:0] retry_minutes;
   } cfg_type;

   typedef struct packed {
      logic [1:0] operation;
      logic       user_on;
      logic       safe_mode;
      logic       radio_enabled;
      logic       linked;
      logic       busy_req;
      logic       away;
   } item_type;

   typedef struct packed {
      logic        intent_on;
      logic        parked_flag;
      logic        retry_look_flag;
      logic [15:0] idle_count;
      logic [15:0] park_count;
      logic [1:0]  applied_save_mode;
      logic [2:0]  last_state;
   } state_type;

   typedef struct packed {
      logic [2:0]  policy_state;
      logic        enable_request_valid;
      logic        enable_request_on;
      logic        power_save_change;
      logic        power_save_max;
      logic [15:0] seconds_left;
   } result_type;

   // saturating one-second count
   function automatic logic [15:0] sat_inc(input logic [15:0] v);
      return (v == COUNT_MAX) ? v : v + 16'd1;
   endfunction

   // minutes to seconds, at most 1023 * 60 which fits 16 bits
   function automatic logic [15:0] to_seconds(input logic [9:0] mins);
      return 16'(16'(mins) * SECS_PER_MIN);
   endfunction

endpackage
`default_nettype wire

@@ sv/rip_csr.sv @@
`default_nettype none
module rip_csr (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             csr_valid,
   output logic                  csr_ready,
   input  wire logic [1:0]       csr_index,
   input  wire logic [9:0]       csr_wdata,
   output rip_pkg::cfg_type      cfg
);
   import rip_pkg::*;

   cfg_type cfg_ff, cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_AUTO_PARK:  cfg_in.auto_park_enable  = csr_wdata[0];
            REG_POWER_SAVE: cfg_in.power_save_enable = csr_wdata[0];
            REG_IDLE_MIN:   cfg_in.idle_minutes      = csr_wdata;
            REG_RETRY_MIN:  cfg_in.retry_minutes     = csr_wdata;
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.auto_park_enable  <= 1'b1;
         cfg_ff.power_save_enable <= 1'b1;
         cfg_ff.idle_minutes      <= 10'd5;
         cfg_ff.retry_minutes     <= 10'd15;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule
`default_nettype wire

@@ sv/rip_eval.sv @@
`default_nettype none
module rip_eval (
   input  wire rip_pkg::item_type   item,
   input  wire rip_pkg::state_type  st,
   input  wire rip_pkg::cfg_type    cfg,
   output rip_pkg::state_type       nxt,
   output rip_pkg::result_type      res
);
   import rip_pkg::*;

   logic [15:0] retry_secs;
   logic [15:0] idle_secs;
   logic [15:0] limit;
   logic [15:0] idle_base;
   logic [15:0] idle_inc;
   logic [15:0] park_inc;
   logic [1:0]  want_mode;
   logic [9:0]  mins;

   // limits from configuration
   assign mins       = (cfg.idle_minutes == 10'd0) ? 10'd1 : cfg.idle_minutes;
   assign retry_secs = to_seconds(cfg.retry_minutes);
   assign idle_secs  = to_seconds(mins);
   assign park_inc   = sat_inc(st.park_count);

   // idle count restarts when a parked radio is found up again
   assign idle_base = (st.parked_flag && item.radio_enabled) ? 16'd0 : st.idle_count;
   assign idle_inc  = sat_inc(idle_base);
   assign limit     = st.retry_look_flag ? LOOK_SECONDS
                    : (item.away ? AWAY_SECONDS : idle_secs);

   assign want_mode = (!item.busy_req && cfg.power_save_enable) ? SAVE_MAX : SAVE_MIN;

   // policy evaluation for one word
   always_comb begin
      nxt = st;
      res = '0;
      case (item.operation)
         OP_INTENT: begin
            nxt.intent_on       = item.user_on;
            nxt.parked_flag     = 1'b0;
            nxt.retry_look_flag = 1'b0;
            nxt.idle_count      = 16'd0;
            nxt.park_count      = 16'd0;
         end
         OP_WAKE: begin
            if (st.parked_flag) begin
               nxt.parked_flag          = 1'b0;
               nxt.retry_look_flag      = 1'b0;
               nxt.idle_count           = 16'd0;
               res.enable_request_valid = 1'b1;
               res.enable_request_on    = 1'b1;
            end
         end
         OP_TICK: begin
            if (!st.intent_on || item.safe_mode) begin
               nxt.parked_flag = 1'b0;
               nxt.last_state  = ST_OFF;
            end else if (st.parked_flag && !item.radio_enabled) begin
               // parked: count towards the retry wake
               nxt.park_count = park_inc;
               if (retry_secs != 16'd0 && park_inc >= retry_secs) begin
                  nxt.park_count           = 16'd0;
                  nxt.retry_look_flag      = 1'b1;
                  res.enable_request_valid = 1'b1;
                  res.enable_request_on    = 1'b1;
               end
               res.seconds_left = (retry_secs != 16'd0) ? retry_secs - nxt.park_count : 16'd0;
               nxt.last_state   = ST_PARKED;
            end else if (!item.radio_enabled) begin
               nxt.last_state = ST_WAKING;
            end else begin
               nxt.parked_flag = 1'b0;
               if (item.linked) begin
                  // linked: pick modem sleep
                  nxt.retry_look_flag   = 1'b0;
                  nxt.idle_count        = 16'd0;
                  nxt.applied_save_mode = want_mode;
                  res.power_save_change = (want_mode != st.applied_save_mode);
                  nxt.last_state        = item.busy_req ? ST_BUSY : ST_LINK_IDLE;
               end else begin
                  // searching: minimum sleep, idle countdown to park
                  nxt.applied_save_mode = SAVE_MIN;
                  res.power_save_change = (st.applied_save_mode != SAVE_MIN);
                  if (item.busy_req) begin
                     nxt.idle_count = 16'd0;
                     nxt.last_state = ST_BUSY;
                  end else if (cfg.auto_park_enable && idle_inc >= limit) begin
                     res.enable_request_valid = 1'b1;
                     res.enable_request_on    = 1'b0;
                     nxt.parked_flag          = 1'b1;
                     nxt.park_count           = 16'd0;
                     nxt.idle_count           = 16'd0;
                     nxt.retry_look_flag      = 1'b0;
                     nxt.last_state           = ST_PARKED;
                  end else begin
                     nxt.idle_count   = idle_inc;
                     res.seconds_left = cfg.auto_park_enable ? limit - idle_inc : 16'd0;
                     nxt.last_state   = ST_SEARCH;
                  end
               end
            end
         end
         default: nxt = st;
      endcase
      res.policy_state   = nxt.last_state;
      res.power_save_max = (nxt.applied_save_mode == SAVE_MAX);
   end

endmodule
`default_nettype wire

@@ sv/radio_idle_park_policy.sv @@
// channel   | direction | words
// req_      | in        | one tick, intent or wake word
// rsp_      | out       | one policy result per request word
// csr_      | in        | register index and write data
//
// one word a cycle sustained while rsp_ready holds; results come from the result register
// the input register feeds the policy logic, which updates state and loads the result register
// the result register holds a stalled result while the input register takes the next word
// reset is synchronous: policy state and valid flags return to defaults, payload does not
// a stalled result stops the policy logic; req_ready drops only when both registers are full
`default_nettype none
module radio_idle_park_policy (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_operation,
   input  wire logic        req_user_on,
   input  wire logic        req_safe_mode,
   input  wire logic        req_radio_enabled,
   input  wire logic        req_linked,
   input  wire logic        req_busy_req,
   input  wire logic        req_away,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_policy_state,
   output logic             rsp_enable_request_valid,
   output logic             rsp_enable_request_on,
   output logic             rsp_power_save_change,
   output logic             rsp_power_save_max,
   output logic [15:0]      rsp_seconds_left,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [9:0]  csr_wdata
);
   import rip_pkg::*;

   cfg_type    cfg;
   item_type   item_ff, item_in;
   logic       in_valid_ff, in_valid_in;
   state_type  state_ff, state_in;
   result_type res_ff, res_in;
   logic       out_valid_ff, out_valid_in;
   logic       advance;

   rip_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   rip_eval u_eval (
      .item (item_ff),
      .st   (state_ff),
      .cfg  (cfg),
      .nxt  (state_in),
      .res  (res_in)
   );

   // pipeline handshake
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;

   assign item_in = '{operation:     req_operation,
                      user_on:       req_user_on,
                      safe_mode:     req_safe_mode,
                      radio_enabled: req_radio_enabled,
                      linked:        req_linked,
                      busy_req:      req_busy_req,
                      away:          req_away};

   assign in_valid_in  = (req_valid && req_ready) || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_ready);

   // control and policy state
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff                <= 1'b0;
         out_valid_ff               <= 1'b0;
         state_ff.intent_on         <= 1'b1;
         state_ff.parked_flag       <= 1'b0;
         state_ff.retry_look_flag   <= 1'b0;
         state_ff.idle_count        <= 16'd0;
         state_ff.park_count        <= 16'd0;
         state_ff.applied_save_mode <= SAVE_NONE;
         state_ff.last_state        <= ST_OFF;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         if (advance) begin
            state_ff <= state_in;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= item_in;
      end
      if (advance) begin
         res_ff <= res_in;
      end
   end

   assign rsp_valid                = out_valid_ff;
   assign rsp_policy_state         = res_ff.policy_state;
   assign rsp_enable_request_valid = res_ff.enable_request_valid;
   assign rsp_enable_request_on    = res_ff.enable_request_on;
   assign rsp_power_save_change    = res_ff.power_save_change;
   assign rsp_power_save_max       = res_ff.power_save_max;
   assign rsp_seconds_left         = res_ff.seconds_left;

endmodule
`default_nettype wire

@@ sv/rip_checker.sv @@
`default_nettype none
module rip_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [2:0]  rsp_policy_state,
   input wire logic        rsp_enable_request_valid,
   input wire logic        rsp_enable_request_on,
   input wire logic [15:0] rsp_seconds_left
);
   import rip_pkg::*;

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_policy_state)
                                 && $stable(rsp_seconds_left))
      else $error("stalled result changed");

   // a start request is always flagged as a request
   a_req_on: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enable_request_on |-> rsp_enable_request_valid)
      else $error("start without request flag");

   // a stop request only comes with the parking word
   a_stop_parks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_enable_request_valid && !rsp_enable_request_on
      |-> rsp_policy_state == ST_PARKED)
      else $error("stop request outside parking");

   // nothing counts down in the off state
   a_off_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_policy_state == ST_OFF |-> rsp_seconds_left == 16'd0)
      else $error("countdown while off");

   // no result straight out of reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result after reset");

endmodule

bind radio_idle_park_policy rip_checker u_rip_checker (
   .clock                    (clock),
   .reset                    (reset),
   .rsp_valid                (rsp_valid),
   .rsp_ready                (rsp_ready),
   .rsp_policy_state         (rsp_policy_state),
   .rsp_enable_request_valid (rsp_enable_request_valid),
   .rsp_enable_request_on    (rsp_enable_request_on),
   .rsp_seconds_left         (rsp_seconds_left)
);
`default_nettype wire
